@@ design/hcrp_pkg.sv @@
package hcrp_pkg;

    localparam int LEN_W      = 12;
    localparam int LINE_LIMIT = 2048;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // line states
    localparam logic [3:0] LS_FIRST      = 4'd0;
    localparam logic [3:0] LS_FIRST_CR   = 4'd1;
    localparam logic [3:0] LS_STATUS_END = 4'd2;
    localparam logic [3:0] LS_HDR        = 4'd3;
    localparam logic [3:0] LS_HDR_CR     = 4'd4;
    localparam logic [3:0] LS_HDR_END    = 4'd5;
    localparam logic [3:0] LS_BLANK_CR   = 4'd6;
    localparam logic [3:0] LS_DONE       = 4'd7;

    // match phases
    localparam logic [2:0] MP_PREFIX     = 3'd0;
    localparam logic [2:0] MP_SPACES     = 3'd1;
    localparam logic [2:0] MP_CODE       = 3'd2;
    localparam logic [2:0] MP_OK         = 3'd3;
    localparam logic [2:0] MP_BAD_PREFIX = 3'd4;
    localparam logic [2:0] MP_BAD_CODE   = 3'd5;

    // outcome codes
    localparam logic [2:0] OUT_BUSY     = 3'd0;
    localparam logic [2:0] OUT_OK       = 3'd1;
    localparam logic [2:0] OUT_INVALID  = 3'd2;
    localparam logic [2:0] OUT_NOT_200  = 3'd3;
    localparam logic [2:0] OUT_TOO_LONG = 3'd4;
    localparam logic [2:0] OUT_CLOSED   = 3'd5;

    typedef struct packed {
        logic [3:0] next_state;
        logic       in_status;
        logic       status_end;
        logic       hdr_end;
        logic       done;
    } line_info_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] pos;
    } match_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        case (pos)
            4'd0:    prefix_char = 8'h48; // H
            4'd1:    prefix_char = 8'h54; // T
            4'd2:    prefix_char = 8'h54; // T
            4'd3:    prefix_char = 8'h50; // P
            4'd4:    prefix_char = 8'h2F; // /
            4'd5:    prefix_char = 8'h31; // 1
            4'd6:    prefix_char = 8'h2E; // .
            4'd7:    prefix_char = 8'h30; // 0
            4'd8:    prefix_char = 8'h20; // space
            default: prefix_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] code_char(input logic [3:0] pos);
        case (pos)
            4'd0:    code_char = 8'h32; // 2
            4'd1:    code_char = 8'h30; // 0
            4'd2:    code_char = 8'h30; // 0
            default: code_char = 8'h00;
        endcase
    endfunction

endpackage

@@ design/hcrp_line_fsm.sv @@
module hcrp_line_fsm
    import hcrp_pkg::*;
(
    input  logic [3:0] state,
    input  logic [7:0] rx_byte,
    input  logic       ignore_cr,
    output line_info_t info
);

    logic       is_cr;
    logic       is_lf;
    logic       lf_ends;
    logic [3:0] ns;

    assign is_cr   = (rx_byte == CH_CR);
    assign is_lf   = (rx_byte == CH_LF);
    assign lf_ends = ignore_cr && is_lf;

    always_comb begin
        case (state)
            LS_FIRST: begin
                if (is_cr)        ns = LS_FIRST_CR;
                else if (lf_ends) ns = LS_STATUS_END;
                else              ns = LS_FIRST;
            end
            LS_FIRST_CR: begin
                ns = is_lf ? LS_STATUS_END : LS_FIRST;
            end
            LS_STATUS_END, LS_HDR_END: begin
                if (is_cr)        ns = LS_BLANK_CR;
                else if (lf_ends) ns = LS_DONE;
                else              ns = LS_HDR;
            end
            LS_HDR_CR: begin
                ns = is_lf ? LS_HDR_END : LS_HDR;
            end
            LS_BLANK_CR: begin
                // a repeated CR waits for its LF only when bare LF is allowed
                if (is_lf)      ns = LS_DONE;
                else if (is_cr) ns = ignore_cr ? LS_BLANK_CR : LS_HDR_CR;
                else            ns = LS_HDR;
            end
            LS_DONE: begin
                ns = LS_DONE;
            end
            default: begin
                if (is_cr)        ns = LS_HDR_CR;
                else if (lf_ends) ns = LS_HDR_END;
                else              ns = LS_HDR;
            end
        endcase
    end

    assign info.next_state = ns;
    assign info.in_status  = (state == LS_FIRST) || (state == LS_FIRST_CR);
    assign info.status_end = (ns == LS_STATUS_END);
    assign info.hdr_end    = (ns == LS_HDR_END);
    assign info.done       = (ns == LS_DONE);

endmodule

@@ design/hcrp_matcher.sv @@
module hcrp_matcher
    import hcrp_pkg::*;
(
    input  match_t     cur,
    input  logic [7:0] rx_byte,
    output match_t     nxt
);

    logic ok;

    always_comb begin
        nxt = cur;
        ok  = 1'b0;
        case (cur.phase)
            MP_PREFIX: begin
                // minor version may be 0 or 1
                if (cur.pos == 4'd7) ok = (rx_byte == 8'h30) || (rx_byte == 8'h31);
                else                 ok = (cur.pos < 4'd9) && (rx_byte == prefix_char(cur.pos));
                if (!ok) begin
                    nxt.phase = MP_BAD_PREFIX;
                end else if (cur.pos == 4'd8) begin
                    nxt.phase = MP_SPACES;
                    nxt.pos   = 4'd0;
                end else begin
                    nxt.pos = cur.pos + 4'd1;
                end
            end
            MP_SPACES: begin
                if (rx_byte != CH_SPACE) begin
                    if (rx_byte == code_char(4'd0)) begin
                        nxt.phase = MP_CODE;
                        nxt.pos   = 4'd1;
                    end else begin
                        nxt.phase = MP_BAD_CODE;
                    end
                end
            end
            MP_CODE: begin
                if (cur.pos >= 4'd3 || rx_byte != code_char(cur.pos)) nxt.phase = MP_BAD_CODE;
                else if (cur.pos == 4'd2)                            nxt.phase = MP_OK;
                else                                                 nxt.pos = cur.pos + 4'd1;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

@@ design/http_connect_reply_parser.sv @@
// An accepted byte waits in the input register until the result register can advance; it is
// then processed and its result word is presented on the m_ side from the result register.
// Throughput: one byte per cycle unless m_ready holds back the result register; the line
// and match state update in a single pass.
// Reset (synchronous, aresetn low): parser back to the start of the status line,
// outcome busy, ignore_cr cleared, both pipeline stages emptied.
module http_connect_reply_parser
    import hcrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_link_closed,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_outcome,
    output logic       m_status_line_end,
    output logic       m_header_line_end
);

    logic             ignore_cr_reg;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_closed_reg;

    logic [3:0]       line_state_reg, line_state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    match_t           match_reg, match_next;
    logic [2:0]       outcome_reg, outcome_next;

    logic             out_valid_reg;
    logic [2:0]       out_outcome_reg;
    logic             out_st_reg, out_hd_reg;
    logic             st_next, hd_next;

    line_info_t       li;
    match_t           match_fed;
    logic             adv;
    logic             proc;
    logic [LEN_W-1:0] len_inc;

    hcrp_line_fsm u_line (
        .state     (line_state_reg),
        .rx_byte   (in_byte_reg),
        .ignore_cr (ignore_cr_reg),
        .info      (li)
    );

    hcrp_matcher u_match (
        .cur     (match_reg),
        .rx_byte (in_byte_reg),
        .nxt     (match_fed)
    );

    assign adv       = !out_valid_reg || m_ready;
    assign proc      = in_valid_reg && adv;
    assign s_ready   = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign len_inc   = len_reg + 1'b1;

    always_comb begin
        line_state_next = line_state_reg;
        len_next        = len_reg;
        match_next      = match_reg;
        outcome_next    = outcome_reg;
        st_next         = 1'b0;
        hd_next         = 1'b0;
        if (outcome_reg == OUT_BUSY) begin
            if (in_closed_reg) begin
                outcome_next = OUT_CLOSED;
            end else begin
                line_state_next = li.next_state;
                len_next        = len_inc;
                // the terminating byte is not fed to the matcher
                if (li.in_status && !li.status_end) match_next = match_fed;
                if (li.status_end) begin
                    st_next  = 1'b1;
                    len_next = '0;
                    if (match_reg.phase inside {MP_SPACES, MP_CODE, MP_BAD_CODE})
                        outcome_next = OUT_NOT_200;
                    else if (match_reg.phase != MP_OK)
                        outcome_next = OUT_INVALID;
                end else if (li.hdr_end) begin
                    hd_next  = 1'b1;
                    len_next = '0;
                end else if (len_inc >= LEN_W'(LINE_LIMIT)) begin
                    outcome_next = OUT_TOO_LONG;
                end else if (li.done) begin
                    outcome_next = OUT_OK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_cr_reg   <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            line_state_reg  <= LS_FIRST;
            len_reg         <= '0;
            match_reg.phase <= MP_PREFIX;
            match_reg.pos   <= 4'd0;
            outcome_reg     <= OUT_BUSY;
        end else begin
            if (cfg_valid && cfg_ready) ignore_cr_reg <= cfg_data;
            if (s_ready) in_valid_reg <= s_valid;
            if (adv) out_valid_reg <= in_valid_reg;
            if (proc) begin
                line_state_reg <= line_state_next;
                len_reg        <= len_next;
                match_reg      <= match_next;
                outcome_reg    <= outcome_next;
            end
        end
    end

    // payload: load the input word on accept, the result word when a held byte is processed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg   <= s_rx_byte;
            in_closed_reg <= s_link_closed;
        end
        if (proc) begin
            out_outcome_reg <= outcome_next;
            out_st_reg      <= st_next;
            out_hd_reg      <= hd_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_outcome         = out_outcome_reg;
    assign m_status_line_end = out_st_reg;
    assign m_header_line_end = out_hd_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status_line_end && m_header_line_end))
        else $error("status and header line end flagged together");

    a_outcome_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (outcome_reg != OUT_BUSY) |=> (outcome_reg == $past(outcome_reg)))
        else $error("final outcome changed after being set");

    a_hdr_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_header_line_end) |-> (m_outcome == OUT_BUSY))
        else $error("header line end reported with a final outcome");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (outcome_reg == OUT_BUSY) |-> (len_reg < LEN_W'(LINE_LIMIT)))
        else $error("line length reached limit while busy");

endmodule
